[sv/cbid_pkg.sv]
`timescale 1ns / 1ps
// Package for the character buffer insert/delete unit: transaction payload types,
// request codes and the control bundle broadcast to the cells. No dependencies.
package cbid_pkg;

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_DELETE = 2'd1;
	localparam logic [1:0] REQ_READ   = 2'd2;

	localparam logic [6:0] BUF_LEN_RESET = 7'd64;

	typedef struct packed {
		logic [1:0] req_type;
		logic [5:0] position;
		logic [7:0] char_value;
	} req_t;

	typedef struct packed {
		logic       success;
		logic [7:0] read_byte;
	} resp_t;

	// Command seen by every cell in the cycle a request is accepted. The
	// operation flags are already qualified by the position range check.
	typedef struct packed {
		logic       do_insert;
		logic       do_delete;
		logic       do_read;
		logic [7:0] value;
	} cell_ctl_t;

endpackage

[sv/cbid_cell.sv]
`timescale 1ns / 1ps
// One byte slot of the character buffer chain. Shifts from either neighbour,
// ripples the delete match prefix and the read data. Depends on cbid_pkg.
module cbid_cell #(
	parameter int IDX        = 0,
	parameter int IDX_W      = 6,
	parameter int LEN_W      = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cbid_pkg::cell_ctl_t ctl,
	input  logic [IDX_W-1:0]   pos,
	input  logic [LEN_W-1:0]   len,
	input  logic [7:0]         left_data,
	input  logic [7:0]         right_data,
	input  logic               found_in,
	output logic               found_out,
	input  logic [7:0]         rd_in,
	output logic [7:0]         rd_out,
	output logic [7:0]         data
);
	import cbid_pkg::*;

	logic [7:0] data_q;
	logic       in_use;
	logic       is_last;
	logic       before_end;
	logic       at_pos;
	logic       after_pos;
	logic       from_pos;
	logic       match;

	assign in_use     = LEN_W'(IDX) < len;
	assign is_last    = LEN_W'(IDX + 1) == len;
	assign before_end = LEN_W'(IDX + 1) < len;
	assign at_pos     = IDX_W'(IDX) == pos;
	assign after_pos  = IDX_W'(IDX) > pos;
	assign from_pos   = !(IDX_W'(IDX) < pos);

	// The last slot in use never takes part in the search.
	assign match     = ctl.do_delete && from_pos && before_end && (data_q == ctl.value);
	assign found_out = found_in | match;

	assign rd_out = rd_in | ((ctl.do_read && at_pos) ? data_q : 8'd0);
	assign data   = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= 8'd0;
		end else if (ctl.do_insert) begin
			if (at_pos) begin
				data_q <= ctl.value;
			end else if (after_pos && in_use) begin
				data_q <= left_data;
			end
		end else if (ctl.do_delete) begin
			// Slots from the first match onwards close the gap; the last slot
			// in use is cleared on every delete whether or not a match was found.
			if ((found_in || match) && before_end) begin
				data_q <= right_data;
			end else if (is_last) begin
				data_q <= 8'd0;
			end
		end
	end

endmodule

[sv/char_buffer_insert_delete_unit.sv]
`timescale 1ns / 1ps
// Character buffer with insert, delete-first-match and read requests.
// Response: registered at the edge that accepts the request.
// Throughput: one request per cycle while responses are taken, set by the single
// ripple of the match prefix along the chain of byte cells.
// Reset: all slots cleared to zero at once and the used length set to 64; no clearing pass.
// Depends on cbid_pkg and cbid_cell.
module char_buffer_insert_delete_unit #(
	parameter int MAX_LENGTH = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  cbid_pkg::req_t in_item,
	output logic           out_valid,
	input  logic           out_ready,
	output cbid_pkg::resp_t out_item,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [6:0]     cfg_data
);
	import cbid_pkg::*;

	localparam int IDX_W = $clog2(MAX_LENGTH);
	localparam int LEN_W = $clog2(MAX_LENGTH + 1);
	localparam int CW    = (LEN_W > 7) ? LEN_W : 7;

	logic [6:0]       buffer_length_q;
	logic             out_valid_q;
	resp_t            out_item_q;
	logic [CW-1:0]    len_wide;
	logic [LEN_W-1:0] elen;
	logic             pos_ok;
	logic [IDX_W-1:0] pos_idx;
	logic             accept;
	cell_ctl_t        ctl;
	resp_t            resp;

	logic [7:0] cell_data [MAX_LENGTH];
	logic       found     [MAX_LENGTH+1];
	logic [7:0] rd_chain  [MAX_LENGTH+1];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_length_q <= BUF_LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			buffer_length_q <= cfg_data;
		end
	end

	// Effective length saturates at the number of physical slots.
	assign len_wide = (CW'(buffer_length_q) > CW'(MAX_LENGTH)) ? CW'(MAX_LENGTH)
	                                                           : CW'(buffer_length_q);
	assign elen     = LEN_W'(len_wide);
	assign pos_ok   = CW'(in_item.position) < len_wide;
	assign pos_idx  = IDX_W'(in_item.position);

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	always_comb begin
		ctl.do_insert = accept && pos_ok && (in_item.req_type == REQ_INSERT);
		ctl.do_delete = accept && pos_ok && (in_item.req_type == REQ_DELETE);
		ctl.do_read   = accept && pos_ok && (in_item.req_type == REQ_READ);
		ctl.value     = in_item.char_value;
	end

	assign found[0]    = 1'b0;
	assign rd_chain[0] = 8'd0;

	for (genvar i = 0; i < MAX_LENGTH; i++) begin : g_cell
		logic [7:0] left_d;
		logic [7:0] right_d;
		if (i == 0) begin : g_first
			assign left_d = 8'd0;
		end else begin : g_mid_l
			assign left_d = cell_data[i-1];
		end
		if (i == MAX_LENGTH - 1) begin : g_last
			assign right_d = 8'd0;
		end else begin : g_mid_r
			assign right_d = cell_data[i+1];
		end
		cbid_cell #(
			.IDX       (i),
			.IDX_W     (IDX_W),
			.LEN_W     (LEN_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.pos       (pos_idx),
			.len       (elen),
			.left_data (left_d),
			.right_data(right_d),
			.found_in  (found[i]),
			.found_out (found[i+1]),
			.rd_in     (rd_chain[i]),
			.rd_out    (rd_chain[i+1]),
			.data      (cell_data[i])
		);
	end

	always_comb begin
		resp.read_byte = rd_chain[MAX_LENGTH];
		case (in_item.req_type)
			REQ_INSERT: resp.success = pos_ok;
			REQ_DELETE: resp.success = found[MAX_LENGTH];
			REQ_READ:   resp.success = pos_ok;
			default:    resp.success = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_item_q <= resp;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// An out-of-range position must fail and report a zero byte.
	a_range_fail: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !pos_ok |=> out_valid && !out_item.success && out_item.read_byte == 8'd0)
		else $error("out-of-range request did not fail cleanly");

	// Only read transactions may return a non-zero byte.
	a_non_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_item.req_type != REQ_READ |=> out_item.read_byte == 8'd0)
		else $error("non-read transaction returned data");

	// An accepted insert lands its byte at the requested slot.
	a_insert_lands: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.do_insert |=> cell_data[$past(pos_idx)] == $past(in_item.char_value))
		else $error("inserted byte not found at its position");

	// A read returns what the addressed slot held when it was accepted.
	a_read_value: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.do_read |=> out_item.success && out_item.read_byte == $past(cell_data[pos_idx]))
		else $error("read returned the wrong byte");

endmodule
